/* rtl/pcs_pkg.sv */
`timescale 1ns / 1ps

package pcs_pkg;

  // Sizing
  localparam int unsigned STACK_DEPTH  = 16;
  localparam int unsigned PC_WIDTH     = 16;
  localparam int unsigned SP_WIDTH     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ACT_WIDTH    = 4;
  localparam int unsigned SUM_WIDTH    = ACT_WIDTH + 2;
  localparam int unsigned NUM_PINS     = 4;
  localparam int unsigned LIMIT_WIDTH  = 5;
  localparam int unsigned STEP_WIDTH   = 3;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 5;
  localparam int unsigned ERR_WIDTH    = 2;

  localparam logic [SP_WIDTH-1:0] LIMIT_RESET =
    SP_WIDTH'((STACK_DEPTH < 16) ? STACK_DEPTH : 16);

  // Summed action codes
  localparam logic [SUM_WIDTH-1:0] ACT_NONE   = SUM_WIDTH'(0);
  localparam logic [SUM_WIDTH-1:0] ACT_JUMP   = SUM_WIDTH'(1);
  localparam logic [SUM_WIDTH-1:0] ACT_CALL   = SUM_WIDTH'(2);
  localparam logic [SUM_WIDTH-1:0] ACT_RETURN = SUM_WIDTH'(3);
  localparam logic [SUM_WIDTH-1:0] ACT_SCALL  = SUM_WIDTH'(4);
  localparam logic [SUM_WIDTH-1:0] ACT_SRET   = SUM_WIDTH'(5);
  localparam logic [SUM_WIDTH-1:0] ACT_HALT   = SUM_WIDTH'(6);
  localparam logic [SUM_WIDTH-1:0] ACT_RESET  = SUM_WIDTH'(7);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_ACT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RETURN_ACT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_O_ACT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_F_ACT = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_LIM  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_GROWS_UP   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_WIDTH = CFG_IDX_W'(6);

  // Pin slots in the action table
  localparam int unsigned PIN_JUMP   = 0;
  localparam int unsigned PIN_RETURN = 1;
  localparam int unsigned PIN_FLAG_O = 2;
  localparam int unsigned PIN_FLAG_F = 3;

  // Stack error codes
  localparam logic [ERR_WIDTH-1:0] ERR_NONE      = ERR_WIDTH'(0);
  localparam logic [ERR_WIDTH-1:0] ERR_OVERFLOW  = ERR_WIDTH'(1);
  localparam logic [ERR_WIDTH-1:0] ERR_UNDERFLOW = ERR_WIDTH'(2);

  typedef struct packed {
    logic                jump_pin;
    logic                return_pin;
    logic                flag_o_pin;
    logic                flag_f_pin;
    logic [15:0]         target_address;
    logic                clear_signals;
  } pcs_in_t;

  typedef struct packed {
    logic [15:0]          next_pc;
    logic                 halt_flag;
    logic                 reset_flag;
    logic [ERR_WIDTH-1:0] stack_error;
  } pcs_out_t;

  typedef struct packed {
    logic [NUM_PINS-1:0][ACT_WIDTH-1:0] pin_action;
    logic [SP_WIDTH-1:0]                stack_limit;
    logic                               grows_up;
    logic [STEP_WIDTH-1:0]              word_width;
  } pcs_cfg_t;

  typedef struct packed {
    logic                load;
    logic [SP_WIDTH-1:0] value;
  } pcs_sp_load_t;

  typedef struct packed {
    logic                push;
    logic                pull;
    logic                save0;
    logic [PC_WIDTH-1:0] data;
  } pcs_stack_req_t;

  typedef struct packed {
    logic                full;
    logic                empty;
    logic [PC_WIDTH-1:0] pull_data;
    logic [PC_WIDTH-1:0] slot0_data;
  } pcs_stack_rsp_t;

endpackage

/* rtl/pcs_cfg_regs.sv */
`timescale 1ns / 1ps

module pcs_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [pcs_pkg::CFG_DATA_W-1:0] wr_data_i,
  output pcs_pkg::pcs_cfg_t              cfg_o,
  output pcs_pkg::pcs_sp_load_t          sp_load_o
);

  pcs_pkg::pcs_cfg_t cfg_q, cfg_d;
  logic [pcs_pkg::LIMIT_WIDTH-1:0] limit_raw;
  logic [pcs_pkg::SP_WIDTH-1:0]    limit_clamped;

  // limits beyond the physical depth are held at the depth
  assign limit_raw     = wr_data_i[pcs_pkg::LIMIT_WIDTH-1:0];
  assign limit_clamped = (limit_raw > pcs_pkg::STACK_DEPTH)
                         ? pcs_pkg::SP_WIDTH'(pcs_pkg::STACK_DEPTH)
                         : pcs_pkg::SP_WIDTH'(limit_raw);

  always_comb begin
    cfg_d = cfg_q;
    sp_load_o.load  = 1'b0;
    sp_load_o.value = cfg_q.grows_up ? '0 : limit_clamped;
    if (wr_en_i) begin
      unique case (wr_index_i)
        pcs_pkg::CFG_JUMP_ACT: begin
          cfg_d.pin_action[pcs_pkg::PIN_JUMP] = wr_data_i[pcs_pkg::ACT_WIDTH-1:0];
        end
        pcs_pkg::CFG_RETURN_ACT: begin
          cfg_d.pin_action[pcs_pkg::PIN_RETURN] = wr_data_i[pcs_pkg::ACT_WIDTH-1:0];
        end
        pcs_pkg::CFG_FLAG_O_ACT: begin
          cfg_d.pin_action[pcs_pkg::PIN_FLAG_O] = wr_data_i[pcs_pkg::ACT_WIDTH-1:0];
        end
        pcs_pkg::CFG_FLAG_F_ACT: begin
          cfg_d.pin_action[pcs_pkg::PIN_FLAG_F] = wr_data_i[pcs_pkg::ACT_WIDTH-1:0];
        end
        pcs_pkg::CFG_STACK_LIM: begin
          cfg_d.stack_limit = limit_clamped;
          sp_load_o.load    = 1'b1;
        end
        pcs_pkg::CFG_GROWS_UP: begin
          cfg_d.grows_up = wr_data_i[0];
        end
        pcs_pkg::CFG_WORD_WIDTH: begin
          cfg_d.word_width = wr_data_i[pcs_pkg::STEP_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pin_action  <= '0;
      cfg_q.stack_limit <= pcs_pkg::LIMIT_RESET;
      cfg_q.grows_up    <= 1'b1;
      cfg_q.word_width  <= pcs_pkg::STEP_WIDTH'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/pcs_stack.sv */
`timescale 1ns / 1ps

module pcs_stack (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pcs_pkg::pcs_cfg_t      cfg_i,
  input  pcs_pkg::pcs_sp_load_t  sp_load_i,
  input  pcs_pkg::pcs_stack_req_t req_i,
  output pcs_pkg::pcs_stack_rsp_t rsp_o
);

  logic [pcs_pkg::SP_WIDTH-1:0] sp_q, sp_d;
  logic [pcs_pkg::SP_WIDTH-1:0] sp_inc, sp_dec, pull_idx, wr_idx;
  logic                         full, empty, push_ok, pull_ok, wr_en;

  // return addresses; entries are don't-care until written
  logic [pcs_pkg::PC_WIDTH-1:0] store_q [pcs_pkg::STACK_DEPTH+1];

  assign sp_inc = sp_q + pcs_pkg::SP_WIDTH'(1);
  assign sp_dec = sp_q - pcs_pkg::SP_WIDTH'(1);

  assign full  = cfg_i.grows_up ? (sp_q >= cfg_i.stack_limit) : (sp_q == '0);
  assign empty = cfg_i.grows_up ? (sp_q == '0) : (sp_q >= cfg_i.stack_limit);

  assign push_ok  = req_i.push && !full;
  assign pull_ok  = req_i.pull && !empty;
  assign pull_idx = cfg_i.grows_up ? sp_dec : sp_inc;

  // push writes at the pointer, shallow call always uses slot 0
  assign wr_en  = push_ok || req_i.save0;
  assign wr_idx = req_i.save0 ? '0 : sp_q;

  always_comb begin
    priority if (sp_load_i.load) begin
      sp_d = sp_load_i.value;
    end else if (push_ok) begin
      sp_d = cfg_i.grows_up ? sp_inc : sp_dec;
    end else if (pull_ok) begin
      sp_d = cfg_i.grows_up ? sp_dec : sp_inc;
    end else begin
      sp_d = sp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= req_i.data;
    end
  end

  assign rsp_o.full       = full;
  assign rsp_o.empty      = empty;
  assign rsp_o.pull_data  = store_q[pull_idx];
  assign rsp_o.slot0_data = store_q[0];

endmodule

/* rtl/program_counter_call_stack_unit.sv */
`timescale 1ns / 1ps

// Program counter with a return stack, one instruction cycle per request.
// Input channel (in_valid_i / in_stall_o / in_data_i): pin levels, target
//   address and the clear bit of one instruction cycle.
// Output channel (out_valid_o / out_stall_i / out_data_o): next pc, sticky
//   halt and reset requests, and the stack error code.
// Config channel (cfg_valid_i / cfg_ready_o): register index and data; always
//   ready; written only while no request is in flight, a user rule not enforced.
// Flow: the input register holds a request until the output register is free or
//   draining, then evaluated against pc, stack and flags into the output register.
// Throughput: one request per cycle unless the output stalls; the pc, stack
//   pointer and store update in the same cycle the result is registered, so the
//   next request sees them.
// Reset: pc 0, flags clear, stack pointer 0, stack limit 16, growing up, word
//   width 1, all pin actions none; return store contents are undefined.
// Stall: a stalled result holds in the output register; the input register
//   keeps one more request and in_stall_o rises only when both are full.
module program_counter_call_stack_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pcs_pkg::pcs_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pcs_pkg::pcs_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  pcs_pkg::pcs_cfg_t       cfg;
  pcs_pkg::pcs_sp_load_t   sp_load;
  pcs_pkg::pcs_stack_req_t stack_req_c, stack_req;
  pcs_pkg::pcs_stack_rsp_t stack_rsp;

  // input register
  logic             in_valid_q;
  pcs_pkg::pcs_in_t in_data_q;

  // architectural state
  logic [pcs_pkg::PC_WIDTH-1:0] pc_q, pc_d;
  logic                         halt_q, halt_d;
  logic                         rreq_q, rreq_d;

  // output register
  logic                         out_valid_q;
  pcs_pkg::pcs_out_t            out_data_q;
  logic [pcs_pkg::ERR_WIDTH-1:0] err_c;

  logic                          advance;
  logic                          any_pin;
  logic [pcs_pkg::SUM_WIDTH-1:0] action;

  assign cfg_ready_o = 1'b1;

  pcs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg),
    .sp_load_o  (sp_load)
  );

  pcs_stack u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .sp_load_i (sp_load),
    .req_i     (stack_req),
    .rsp_o     (stack_rsp)
  );

  // Evaluate the held request when the output register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  // Sum the action codes of the active pins.
  assign action =
      (in_data_q.jump_pin ? pcs_pkg::SUM_WIDTH'(cfg.pin_action[pcs_pkg::PIN_JUMP]) : '0)
    + (in_data_q.return_pin ? pcs_pkg::SUM_WIDTH'(cfg.pin_action[pcs_pkg::PIN_RETURN]) : '0)
    + (in_data_q.flag_o_pin ? pcs_pkg::SUM_WIDTH'(cfg.pin_action[pcs_pkg::PIN_FLAG_O]) : '0)
    + (in_data_q.flag_f_pin ? pcs_pkg::SUM_WIDTH'(cfg.pin_action[pcs_pkg::PIN_FLAG_F]) : '0);

  assign any_pin = in_data_q.jump_pin | in_data_q.return_pin
                 | in_data_q.flag_o_pin | in_data_q.flag_f_pin;

  always_comb begin
    pc_d        = pc_q;
    halt_d      = in_data_q.clear_signals ? 1'b0 : halt_q;
    rreq_d      = in_data_q.clear_signals ? 1'b0 : rreq_q;
    err_c       = pcs_pkg::ERR_NONE;
    stack_req_c = '{push: 1'b0, pull: 1'b0, save0: 1'b0, data: pc_q};
    unique case (action)
      pcs_pkg::ACT_JUMP: begin
        pc_d = pcs_pkg::PC_WIDTH'(in_data_q.target_address);
      end
      pcs_pkg::ACT_CALL: begin
        // on overflow nothing is stored but the jump still happens
        stack_req_c.push = 1'b1;
        pc_d             = pcs_pkg::PC_WIDTH'(in_data_q.target_address);
        if (stack_rsp.full) begin
          err_c = pcs_pkg::ERR_OVERFLOW;
        end
      end
      pcs_pkg::ACT_RETURN: begin
        stack_req_c.pull = 1'b1;
        if (stack_rsp.empty) begin
          pc_d  = '1;
          err_c = pcs_pkg::ERR_UNDERFLOW;
        end else begin
          pc_d = stack_rsp.pull_data;
        end
      end
      pcs_pkg::ACT_SCALL: begin
        stack_req_c.save0 = 1'b1;
        pc_d              = pcs_pkg::PC_WIDTH'(in_data_q.target_address);
      end
      pcs_pkg::ACT_SRET: begin
        pc_d = stack_rsp.slot0_data;
      end
      pcs_pkg::ACT_HALT: begin
        halt_d = 1'b1;
      end
      pcs_pkg::ACT_RESET: begin
        rreq_d = 1'b1;
      end
      default: begin
        // none, and sums above seven: no effect
      end
    endcase
    // sequential fetch when no pin is active
    if (!any_pin) begin
      pc_d = pc_q + pcs_pkg::PC_WIDTH'(cfg.word_width);
    end
  end

  // push, pull and slot 0 writes happen only on the cycle the request is evaluated
  always_comb begin
    stack_req       = stack_req_c;
    stack_req.push  = stack_req_c.push && advance;
    stack_req.pull  = stack_req_c.pull && advance;
    stack_req.save0 = stack_req_c.save0 && advance;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      halt_q <= 1'b0;
      rreq_q <= 1'b0;
    end else if (advance) begin
      pc_q   <= pc_d;
      halt_q <= halt_d;
      rreq_q <= rreq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q.next_pc     <= 16'(pc_d);
      out_data_q.halt_flag   <= halt_d;
      out_data_q.reset_flag  <= rreq_d;
      out_data_q.stack_error <= err_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
